FILE: design/llg_pkg.sv
// Shared types, constants and saturating fixed-point helpers for the LLG derivative core.
// Used by llg_div, llg_sqrt and llg_cell_derivative_core; depends on nothing else.
package llg_pkg;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int DAMP_W = 19;
  localparam int GYRO_W = 31;
  localparam int DIV_STEPS = DW - 1;
  localparam int DVW = DW - 1 + FB;
  localparam int SQ_STEPS = (DW + FB) / 2;
  localparam int IN_TDATA_W = ((6 * DW + DAMP_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((3 * DW + 7) / 8) * 8;

  typedef logic signed [DW-1:0] q_t;

  localparam q_t VMAX = {1'b0, {(DW - 1){1'b1}}};
  localparam q_t VMIN = {1'b1, {(DW - 1){1'b0}}};
  localparam q_t ONE = q_t'(64'd1 << FB);

  typedef enum logic [1:0] {
    REG_GYRO = 2'd0,
    REG_PREC = 2'd1,
    REG_GAIN = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic en;
    logic vld;
  } pipe_ctl_t;

  typedef struct packed {
    q_t [2:0] e;
    q_t [2:0] m;
    q_t       mm;
    logic     pin;
    logic     last;
  } div_pay_t;

  typedef struct packed {
    q_t [2:0] d;
    q_t [2:0] m;
    q_t       omm;
    logic     pin;
    logic     last;
  } sq_pay_t;

  function automatic q_t qadd(input q_t a, input q_t b);
    logic [DW:0] s;
    q_t r;
    s = {a[DW-1], a} + {b[DW-1], b};
    if (s[DW] != s[DW-1]) r = s[DW] ? VMIN : VMAX;
    else r = q_t'(s[DW-1:0]);
    return r;
  endfunction

  function automatic q_t qsub(input q_t a, input q_t b);
    logic [DW:0] s;
    q_t r;
    s = {a[DW-1], a} - {b[DW-1], b};
    if (s[DW] != s[DW-1]) r = s[DW] ? VMIN : VMAX;
    else r = q_t'(s[DW-1:0]);
    return r;
  endfunction

  function automatic q_t qmul(input q_t a, input q_t b);
    logic [DW-1:0] ma;
    logic [DW-1:0] mb;
    logic [2*DW-1:0] p;
    logic neg;
    q_t r;
    ma = a[DW-1] ? (~a + 1'b1) : a;
    mb = b[DW-1] ? (~b + 1'b1) : b;
    neg = a[DW-1] ^ b[DW-1];
    p = ({{DW{1'b0}}, ma} * {{DW{1'b0}}, mb}) >> FB;
    if (p > {{DW{1'b0}}, VMAX}) r = neg ? VMIN : VMAX;
    else if (neg) r = -q_t'(p[DW-1:0]);
    else r = q_t'(p[DW-1:0]);
    return r;
  endfunction

endpackage

FILE: design/llg_cell_derivative_core.sv
// Landau-Lifshitz-Gilbert derivative core: top level with the arithmetic stages.
// Depends on llg_pkg, llg_div and llg_sqrt.
//
// One cell word enters per clock and one derivative word leaves per clock in steady
// state while the output is not stalled. At Q16.16 the pipeline is built thus: six
// stages form the perpendicular field and damping terms, a divider with one stage
// per quotient bit forms gamma / (1 + alpha^2), three stages scale and square the
// derivative, a square-root pipeline with one stage per root bit forms its
// magnitude, and four stages apply the norm correction and register the result.
// A stall on the output holds the whole pipeline in place. Configuration writes are
// always taken and must be made while no cell is in flight.
module llg_cell_derivative_core
  import llg_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // mag_x, mag_y, mag_z, field_x, field_y, field_z, damping, zero fill
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // pinned
  input  logic                   s_axis_tuser,
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // rate_x, rate_y, rate_z
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [1:0]             cfg_index_i,
  input  logic [DW-1:0]          cfg_data_i
);

  logic [GYRO_W-1:0] gyro_q;
  logic              prec_q;
  q_t                gain_q;
  logic              pipe_en;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gyro_q <= GYRO_W'(32'd65536);
      prec_q <= 1'b1;
      gain_q <= -ONE;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_GYRO: gyro_q <= cfg_data_i[GYRO_W-1:0];
        REG_PREC: prec_q <= cfg_data_i[0];
        REG_GAIN: gain_q <= q_t'(cfg_data_i);
        default: ;
      endcase
    end
  end

  logic [13:1] vld_q;
  logic        div_vld, sq_vld;
  pipe_ctl_t   div_ctl, sq_ctl;

  assign pipe_en       = !vld_q[13] || m_axis_tready;
  assign s_axis_tready = pipe_en;

  assign div_ctl.en  = pipe_en;
  assign div_ctl.vld = vld_q[6];
  assign sq_ctl.en   = pipe_en;
  assign sq_ctl.vld  = vld_q[9];

  q_t [2:0] in_m, in_h;
  q_t       in_alpha;

  for (genvar k = 0; k < 3; k++) begin : g_in
    assign in_m[k] = q_t'(s_axis_tdata[k*DW +: DW]);
    assign in_h[k] = q_t'(s_axis_tdata[(k+3)*DW +: DW]);
  end
  assign in_alpha = q_t'(s_axis_tdata[6*DW +: DAMP_W]);

  q_t [2:0] p1_pm, p1_pmh, p1_m, p1_h;
  q_t       p1_aa, p1_alpha;
  logic     p1_pin, p1_last;
  q_t [2:0] p2_m, p2_h;
  q_t       p2_mm, p2_mh, p2_den, p2_alpha, den_sum;
  logic     p2_pin, p2_last;
  q_t [2:0] p3_t1, p3_t2, p3_m;
  q_t       p3_mm, p3_den, p3_alpha;
  logic     p3_pin, p3_last;
  q_t [2:0] p4_hp, p4_m;
  q_t       p4_mm, p4_den, p4_alpha;
  logic     p4_pin, p4_last;
  q_t [2:0] p5_xa, p5_xb, p5_hpa, p5_m;
  q_t       p5_mm, p5_den;
  logic     p5_pin, p5_last;
  div_pay_t p6_pay, div_pay;
  q_t       p6_den;
  logic [DW-1:0] div_quot;
  q_t [2:0] p7_d, p7_m;
  q_t       p7_mm, coeff;
  logic     p7_pin, p7_last;
  q_t [2:0] p8_sq, p8_d, p8_m;
  q_t       p8_omm;
  logic     p8_pin, p8_last;
  q_t       p9_t;
  sq_pay_t  p9_pay, sq_pay;
  logic [SQ_STEPS-1:0] sq_root;
  q_t       root, c3, c_auto;
  q_t [2:0] p10_d, p10_m;
  q_t       p10_c, p10_omm;
  logic     p10_pin, p10_last;
  q_t [2:0] p11_d, p11_m;
  q_t       p11_cw;
  logic     p11_pin, p11_last;
  q_t [2:0] p12_d, p12_pr;
  logic     p12_pin, p12_last;
  q_t [2:0] p13_r;
  logic     p13_pin, p13_last;

  assign den_sum = qadd(ONE, p1_aa);
  assign coeff   = -q_t'(div_quot);
  assign root    = q_t'(sq_root);
  assign c3      = qadd(qadd(root, root), root);
  assign c_auto  = qadd(c3, c3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q[1]     <= s_axis_tvalid;
      vld_q[6:2]   <= vld_q[5:1];
      vld_q[7]     <= div_vld;
      vld_q[9:8]   <= vld_q[8:7];
      vld_q[10]    <= sq_vld;
      vld_q[13:11] <= vld_q[12:10];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int k = 0; k < 3; k++) begin
        p1_pm[k]  <= qmul(in_m[k], in_m[k]);
        p1_pmh[k] <= qmul(in_m[k], in_h[k]);
      end
      p1_aa    <= qmul(in_alpha, in_alpha);
      p1_m     <= in_m;
      p1_h     <= in_h;
      p1_alpha <= in_alpha;
      p1_pin   <= s_axis_tuser;
      p1_last  <= s_axis_tlast;

      p2_mm    <= qadd(qadd(p1_pm[0], p1_pm[1]), p1_pm[2]);
      p2_mh    <= qadd(qadd(p1_pmh[0], p1_pmh[1]), p1_pmh[2]);
      p2_den   <= (den_sum < q_t'(1)) ? q_t'(1) : den_sum;
      p2_m     <= p1_m;
      p2_h     <= p1_h;
      p2_alpha <= p1_alpha;
      p2_pin   <= p1_pin;
      p2_last  <= p1_last;

      for (int k = 0; k < 3; k++) begin
        p3_t1[k] <= qmul(p2_mm, p2_h[k]);
        p3_t2[k] <= qmul(p2_mh, p2_m[k]);
      end
      p3_m     <= p2_m;
      p3_mm    <= p2_mm;
      p3_den   <= p2_den;
      p3_alpha <= p2_alpha;
      p3_pin   <= p2_pin;
      p3_last  <= p2_last;

      for (int k = 0; k < 3; k++) begin
        p4_hp[k] <= qsub(p3_t1[k], p3_t2[k]);
      end
      p4_m     <= p3_m;
      p4_mm    <= p3_mm;
      p4_den   <= p3_den;
      p4_alpha <= p3_alpha;
      p4_pin   <= p3_pin;
      p4_last  <= p3_last;

      for (int k = 0; k < 3; k++) begin
        p5_xa[k]  <= qmul(p4_m[(k+1)%3], p4_hp[(k+2)%3]);
        p5_xb[k]  <= qmul(p4_m[(k+2)%3], p4_hp[(k+1)%3]);
        p5_hpa[k] <= qmul(p4_hp[k], p4_alpha);
      end
      p5_m    <= p4_m;
      p5_mm   <= p4_mm;
      p5_den  <= p4_den;
      p5_pin  <= p4_pin;
      p5_last <= p4_last;

      for (int k = 0; k < 3; k++) begin
        p6_pay.e[k] <= qsub(prec_q ? qsub(p5_xa[k], p5_xb[k]) : q_t'(0), p5_hpa[k]);
      end
      p6_pay.m    <= p5_m;
      p6_pay.mm   <= p5_mm;
      p6_pay.pin  <= p5_pin;
      p6_pay.last <= p5_last;
      p6_den      <= p5_den;

      for (int k = 0; k < 3; k++) begin
        p7_d[k] <= qmul(coeff, div_pay.e[k]);
      end
      p7_m    <= div_pay.m;
      p7_mm   <= div_pay.mm;
      p7_pin  <= div_pay.pin;
      p7_last <= div_pay.last;

      for (int k = 0; k < 3; k++) begin
        p8_sq[k] <= qmul(p7_d[k], p7_d[k]);
      end
      p8_omm  <= qsub(ONE, p7_mm);
      p8_d    <= p7_d;
      p8_m    <= p7_m;
      p8_pin  <= p7_pin;
      p8_last <= p7_last;

      p9_t        <= qadd(qadd(p8_sq[0], p8_sq[1]), p8_sq[2]);
      p9_pay.d    <= p8_d;
      p9_pay.m    <= p8_m;
      p9_pay.omm  <= p8_omm;
      p9_pay.pin  <= p8_pin;
      p9_pay.last <= p8_last;

      p10_c    <= gain_q[DW-1] ? c_auto : gain_q;
      p10_d    <= sq_pay.d;
      p10_m    <= sq_pay.m;
      p10_omm  <= sq_pay.omm;
      p10_pin  <= sq_pay.pin;
      p10_last <= sq_pay.last;

      p11_cw   <= qmul(p10_c, p10_omm);
      p11_d    <= p10_d;
      p11_m    <= p10_m;
      p11_pin  <= p10_pin;
      p11_last <= p10_last;

      for (int k = 0; k < 3; k++) begin
        p12_pr[k] <= qmul(p11_cw, p11_m[k]);
      end
      p12_d    <= p11_d;
      p12_pin  <= p11_pin;
      p12_last <= p11_last;

      for (int k = 0; k < 3; k++) begin
        p13_r[k] <= p12_pin ? q_t'(0) : qadd(p12_d[k], p12_pr[k]);
      end
      p13_pin  <= p12_pin;
      p13_last <= p12_last;
    end
  end

  llg_div #(
    .PW($bits(div_pay_t))
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl),
    .dividend_i ({gyro_q, {FB{1'b0}}}),
    .divisor_i  (p6_den[DW-2:0]),
    .pay_i      (p6_pay),
    .vld_o      (div_vld),
    .quot_o     (div_quot),
    .pay_o      (div_pay)
  );

  llg_sqrt #(
    .PW($bits(sq_pay_t))
  ) u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (sq_ctl),
    .radicand_i (p9_t[DW-2:0]),
    .pay_i      (p9_pay),
    .vld_o      (sq_vld),
    .root_o     (sq_root),
    .pay_o      (sq_pay)
  );

  assign m_axis_tvalid = vld_q[13];
  assign m_axis_tdata  = OUT_TDATA_W'({p13_r[2], p13_r[1], p13_r[0]});
  assign m_axis_tlast  = p13_last;

  a_pinned_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[13] && p13_pin) |-> (m_axis_tdata == '0))
    else $error("pinned cell produced a nonzero derivative");

  a_den_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] |-> (p2_den >= ONE))
    else $error("damping denominator fell below one");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> ($stable(vld_q) && $stable(p7_d)))
    else $error("pipeline moved during an output stall");

endmodule

FILE: design/llg_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a side payload.
// Depends on llg_pkg.
module llg_div
  import llg_pkg::*;
#(
  parameter int PW = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pipe_ctl_t       ctl_i,
  input  logic [DVW-1:0]  dividend_i,
  input  logic [DW-2:0]   divisor_i,
  input  logic [PW-1:0]   pay_i,
  output logic            vld_o,
  output logic [DW-1:0]   quot_o,
  output logic [PW-1:0]   pay_o
);

  logic [DIV_STEPS-1:0] vld_q;
  logic [DW-2:0]        rem_q [DIV_STEPS];
  logic [DW-2:0]        low_q [DIV_STEPS];
  logic [DW-2:0]        quo_q [DIV_STEPS];
  logic [DW-2:0]        den_q [DIV_STEPS];
  logic [PW-1:0]        pay_q [DIV_STEPS];

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    logic [DW-2:0] rem_in, low_in, quo_in, den_in;
    logic          vld_in;
    logic [PW-1:0] pay_in;
    logic [DW-1:0] trial, diff;
    logic          ge;

    if (s == 0) begin : g_first
      assign rem_in = (DW-1)'(dividend_i >> (DW - 1));
      assign low_in = dividend_i[DW-2:0];
      assign quo_in = '0;
      assign den_in = divisor_i;
      assign vld_in = ctl_i.vld;
      assign pay_in = pay_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign low_in = low_q[s-1];
      assign quo_in = quo_q[s-1];
      assign den_in = den_q[s-1];
      assign vld_in = vld_q[s-1];
      assign pay_in = pay_q[s-1];
    end

    assign trial = {rem_in, low_in[DW-2]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (ctl_i.en) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        rem_q[s] <= ge ? diff[DW-2:0] : trial[DW-2:0];
        low_q[s] <= {low_in[DW-3:0], 1'b0};
        quo_q[s] <= {quo_in[DW-3:0], ge};
        den_q[s] <= den_in;
        pay_q[s] <= pay_in;
      end
    end
  end

  assign vld_o  = vld_q[DIV_STEPS-1];
  assign quot_o = {1'b0, quo_q[DIV_STEPS-1]};
  assign pay_o  = pay_q[DIV_STEPS-1];

endmodule

FILE: design/llg_sqrt.sv
// Pipelined digit-by-digit integer square root of a Q value scaled by 2^FB,
// one root bit per stage, with a side payload. Depends on llg_pkg.
module llg_sqrt
  import llg_pkg::*;
#(
  parameter int PW = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pipe_ctl_t           ctl_i,
  input  logic [DW-2:0]       radicand_i,
  input  logic [PW-1:0]       pay_i,
  output logic                vld_o,
  output logic [SQ_STEPS-1:0] root_o,
  output logic [PW-1:0]       pay_o
);

  localparam int RW = SQ_STEPS + 2;
  localparam int AW = 2 * SQ_STEPS;

  logic [SQ_STEPS-1:0] vld_q;
  logic [RW-1:0]       rem_q  [SQ_STEPS];
  logic [AW-1:0]       arg_q  [SQ_STEPS];
  logic [SQ_STEPS-1:0] root_q [SQ_STEPS];
  logic [PW-1:0]       pay_q  [SQ_STEPS];

  for (genvar s = 0; s < SQ_STEPS; s++) begin : g_step
    logic [RW-1:0]       rem_in, rem2, trial;
    logic [AW-1:0]       arg_in;
    logic [SQ_STEPS-1:0] root_in;
    logic                vld_in;
    logic [PW-1:0]       pay_in;
    logic                ge;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign arg_in  = AW'({radicand_i, {FB{1'b0}}});
      assign root_in = '0;
      assign vld_in  = ctl_i.vld;
      assign pay_in  = pay_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign arg_in  = arg_q[s-1];
      assign root_in = root_q[s-1];
      assign vld_in  = vld_q[s-1];
      assign pay_in  = pay_q[s-1];
    end

    assign rem2  = {rem_in[RW-3:0], arg_in[AW-1:AW-2]};
    assign trial = {root_in, 2'b01};
    assign ge    = rem2 >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (ctl_i.en) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        rem_q[s]  <= ge ? (rem2 - trial) : rem2;
        arg_q[s]  <= {arg_in[AW-3:0], 2'b00};
        root_q[s] <= {root_in[SQ_STEPS-2:0], ge};
        pay_q[s]  <= pay_in;
      end
    end
  end

  assign vld_o  = vld_q[SQ_STEPS-1];
  assign root_o = root_q[SQ_STEPS-1];
  assign pay_o  = pay_q[SQ_STEPS-1];

endmodule

FILE: test/llg_cell_derivative_core_tb.sv
// Self-checking testbench for llg_cell_derivative_core: random and directed cell words
// with random stalls on both streams, checked against an in-bench LLG derivative predictor.
// Depends on llg_pkg and the llg_cell_derivative_core RTL.
module llg_cell_derivative_core_tb;
  import llg_pkg::*;

  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;

  typedef struct {
    logic signed [31:0] mag [3];
    logic signed [31:0] fld [3];
    logic [18:0]        damp;
    logic               pin;
    logic               last;
  } cell_t;

  typedef struct {
    logic signed [31:0] rate [3];
    logic               eom;
  } rate_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [DW-1:0] cfg_data_i = '0;

  cell_t cell_q[$];
  cell_t cur_cell;
  rate_t rate_q[$];
  longint gyro_r, gain_r;
  logic prec_r;
  int fails = 0;
  int cyc = 0;

  llg_cell_derivative_core dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic longint sat(longint v);
    if (v > QMAX) return QMAX;
    if (v < QMIN) return QMIN;
    return v;
  endfunction

  function automatic longint fmul(longint a, longint b);
    longint ma, mb, p;
    logic neg;
    neg = (a < 0) != (b < 0);
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    p = (ma * mb) >>> 16;
    if (p > QMAX) return neg ? QMIN : QMAX;
    return neg ? -p : p;
  endfunction

  function automatic longint froot(longint s);
    longint tgt, r, cand;
    tgt = s <<< 16;
    r = 0;
    for (int b = 23; b >= 0; b--) begin
      cand = r | (64'sd1 <<< b);
      if (cand * cand <= tgt) r = cand;
    end
    return r;
  endfunction

  function automatic rate_t llg_rate(cell_t c);
    rate_t o;
    longint m[3], h[3], hp[3], cr[3], d[3];
    longint al, den, coeff, mm, mh, t, cg, omm;
    for (int i = 0; i < 3; i++) begin
      m[i] = c.mag[i];
      h[i] = c.fld[i];
    end
    al = longint'(c.damp);
    o.eom = c.last;
    if (c.pin) begin
      for (int i = 0; i < 3; i++) o.rate[i] = '0;
      return o;
    end
    den = sat(65536 + fmul(al, al));
    coeff = -sat((gyro_r <<< 16) / den);
    mm = sat(sat(fmul(m[0], m[0]) + fmul(m[1], m[1])) + fmul(m[2], m[2]));
    mh = sat(sat(fmul(m[0], h[0]) + fmul(m[1], h[1])) + fmul(m[2], h[2]));
    for (int i = 0; i < 3; i++) hp[i] = sat(fmul(mm, h[i]) - fmul(mh, m[i]));
    if (prec_r) begin
      cr[0] = sat(fmul(m[1], hp[2]) - fmul(m[2], hp[1]));
      cr[1] = sat(fmul(m[2], hp[0]) - fmul(m[0], hp[2]));
      cr[2] = sat(fmul(m[0], hp[1]) - fmul(m[1], hp[0]));
    end else begin
      cr[0] = 0; cr[1] = 0; cr[2] = 0;
    end
    for (int i = 0; i < 3; i++) d[i] = fmul(coeff, sat(cr[i] - fmul(hp[i], al)));
    if (gain_r < 0) begin
      t = sat(sat(fmul(d[0], d[0]) + fmul(d[1], d[1])) + fmul(d[2], d[2]));
      t = froot(t);
      t = sat(sat(t + t) + t);
      cg = sat(t + t);
    end else begin
      cg = gain_r;
    end
    omm = sat(65536 - mm);
    for (int i = 0; i < 3; i++) o.rate[i] = 32'(sat(d[i] + fmul(fmul(cg, omm), m[i])));
    return o;
  endfunction

  function automatic logic quiet();
    return (cyc > 300 && cyc < 700);
  endfunction

  always @(posedge clk_i) cyc <= cyc + 1;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) rate_q.push_back(llg_rate(cur_cell));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (cell_q.size() != 0 && (quiet() || $urandom_range(99) >= 13)) begin
          cur_cell = cell_q.pop_front();
          s_axis_tdata <= {5'b0, cur_cell.damp, cur_cell.fld[2], cur_cell.fld[1],
                           cur_cell.fld[0], cur_cell.mag[2], cur_cell.mag[1], cur_cell.mag[0]};
          s_axis_tuser <= cur_cell.pin;
          s_axis_tlast <= cur_cell.last;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    rate_t e;
    logic signed [31:0] got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (rate_q.size() == 0) begin
          $error("unexpected word on output");
          fails++;
        end else begin
          e = rate_q.pop_front();
          for (int i = 0; i < 3; i++) begin
            got = m_axis_tdata[32*i +: 32];
            if (got !== e.rate[i]) begin
              $error("rate_%s expected %0d actual %0d",
                     i == 0 ? "x" : (i == 1 ? "y" : "z"), e.rate[i], got);
              fails++;
            end
          end
          if (m_axis_tlast !== e.eom) begin
            $error("end_of_mesh expected %0d actual %0d", e.eom, m_axis_tlast);
            fails++;
          end
        end
      end
      m_axis_tready <= quiet() || $urandom_range(99) >= 13;
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_GYRO: gyro_r = longint'(val[30:0]);
      REG_PREC: prec_r = val[0];
      default: gain_r = longint'(signed'(val));
    endcase
  endtask

  task automatic set_regs(logic [31:0] g, logic p, logic [31:0] k);
    write_reg(REG_GYRO, g);
    write_reg(REG_PREC, {31'b0, p});
    write_reg(REG_GAIN, k);
  endtask

  function automatic logic [31:0] rnd_comp();
    case ($urandom_range(4))
      0: return $urandom;
      1: return 32'($signed($urandom_range(131072)) - 65536);
      2: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return 32'($signed($urandom_range(8192)) - 4096);
    endcase
  endfunction

  task automatic add_cell(logic signed [31:0] mx, logic signed [31:0] my,
                          logic signed [31:0] mz, logic signed [31:0] hx,
                          logic signed [31:0] hy, logic signed [31:0] hz,
                          logic [18:0] al, logic pn, logic lc);
    cell_t c;
    c.mag[0] = mx; c.mag[1] = my; c.mag[2] = mz;
    c.fld[0] = hx; c.fld[1] = hy; c.fld[2] = hz;
    c.damp = al; c.pin = pn; c.last = lc;
    cell_q.push_back(c);
  endtask

  task automatic add_random(int n);
    for (int k = 0; k < n; k++)
      add_cell(rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp(),
               $urandom_range(3) == 0 ? 19'($urandom) : 19'($urandom_range(262144)),
               $urandom_range(9) == 0, $urandom_range(15) == 0);
  endtask

  task automatic drain();
    while (cell_q.size() != 0 || s_axis_tvalid || rate_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_regs(32'd65536, 1'b1, 32'hFFFF0000);
    add_cell(0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_cell(65536, 0, 0, 0, 65536, 0, 0, 0, 0);
    add_cell(65536, 0, 0, 0, 65536, 0, 6554, 0, 1);
    add_cell(0, 0, 65536, 65536, 0, 0, 262144, 0, 0);
    add_cell(0, 0, 65536, 65536, 0, 0, 19'h7FFFF, 0, 0);
    add_cell(60000, 0, 0, 0, 0, 65536, 3277, 0, 0);
    add_cell(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
             32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 19'h7FFFF, 0, 0);
    add_cell(32'h80000000, 32'h80000000, 32'h80000000,
             32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 1);
    add_cell(32'h80000000, 32'h7FFFFFFF, 0, 32'h7FFFFFFF, 32'h80000000, 1, 65536, 0, 0);
    add_cell(32'h7FFFFFFF, 0, 0, 32'h80000000, 0, 0, 262144, 1, 1);
    add_cell(65536, 65536, 65536, -65536, 65536, -65536, 65536, 1, 0);
    add_cell(-1, -1, -1, -1, -1, -1, 1, 0, 0);
    add_cell(46341, 46341, 0, 0, 0, 32'h7FFFFFFF, 0, 0, 1);
    add_random(80);
    drain();
    set_regs(32'h7FFFFFFF, 1'b0, 32'h00000000);
    add_cell(65536, 0, 0, 0, 65536, 0, 0, 0, 0);
    add_cell(30000, 0, 0, 0, 65536, 0, 65536, 0, 1);
    add_random(80);
    drain();
    set_regs(32'h00000000, 1'b1, 32'h7FFFFFFF);
    add_random(80);
    drain();
    set_regs(32'($urandom_range(262144)), 1'b1, 32'($urandom_range(655360)));
    add_random(90);
    drain();
    set_regs($urandom, 1'b0, 32'hFFFFFFFF);
    add_random(80);
    drain();
    set_regs(32'($urandom_range(131072)), 1'b1, 32'h80000000);
    add_random(90);
    drain();
    if (fails == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: llg_cell_derivative_core.f
design/llg_pkg.sv
design/llg_div.sv
design/llg_sqrt.sv
design/llg_cell_derivative_core.sv
test/llg_cell_derivative_core_tb.sv
